/* hw/rtl/ctr_pkg.sv */
`default_nettype none

package ctr_pkg;

  typedef enum logic [1:0] {
    MODE_TO_PROTEIN = 2'd0,
    MODE_TO_CANON   = 2'd1,
    MODE_BACK_CANON = 2'd2,
    MODE_NONE       = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;  // index 0 goes out first
    logic [1:0]      count;  // 0..3 result words
  } ctr_result_t;

  localparam logic [7:0] CHAR_M = 8'h4D;
  localparam logic [23:0] CODON_ATG = 24'h415447;
  localparam logic [23:0] CODON_TAG = 24'h544147;

  // amino acid per codon, index 16*b1 + 4*b2 + b3, entry 0 in the top byte
  localparam logic [64*8-1:0] AA_OF_CODON =
    {"KNKNTTTTRSRSIIMI", "QHQHPPPPRRRRLLLL", "EDEDAAAAGGGGVVVV", "*Y*YSSSS*CWCLFLF"};

  localparam int NumCanon = 21;
  localparam logic [NumCanon*8-1:0] CANON_LETTER = "ARNDCQEGHIMLKFPSTWYV*";
  localparam logic [NumCanon*24-1:0] CANON_CODON =
    {"GCTCGTAATGATTGTCAAGAAGGTCATATT", "ATGTTAAAATTTCCTTCTACTTGGTATGTT", "TAG"};

  // bit 2 set when the byte is a nucleotide, bits 1:0 its code
  function automatic logic [2:0] nuc_code(input logic [7:0] b);
    logic [2:0] r;
    case (b)
      8'h41:   r = 3'b100;
      8'h43:   r = 3'b101;
      8'h47:   r = 3'b110;
      8'h54:   r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] translate(input logic [7:0] b1, input logic [7:0] b2,
                                           input logic [7:0] b3);
    logic [2:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic [5:0] idx;
    logic [7:0] r;
    x = nuc_code(b1);
    y = nuc_code(b2);
    z = nuc_code(b3);
    idx = {x[1:0], y[1:0], z[1:0]};
    if (x[2] && y[2] && z[2]) begin
      r = AA_OF_CODON[(6'd63 - idx)*8 +: 8];
    end else begin
      r = CHAR_M;
    end
    return r;
  endfunction

  function automatic logic [23:0] canonical(input logic [7:0] letter);
    logic [23:0] r;
    r = CODON_ATG;
    for (int i = 0; i < NumCanon; i++) begin
      if (CANON_LETTER[(NumCanon-1-i)*8 +: 8] == letter) begin
        r = CANON_CODON[(NumCanon-1-i)*24 +: 24];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ctr_decode.sv */
`default_nettype none

module ctr_decode
  import ctr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mode_t       mode,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  symbol,
  input  wire logic        closes,
  output logic             res_valid,
  output ctr_result_t      res,
  input  wire logic        res_free
);

  logic       ivalid;
  logic [7:0] sym_q;
  logic       closes_q;
  logic [7:0] codon_bytes [2];
  logic [1:0] codon_position;
  logic [1:0] codon_position_next;
  logic       cb_write;
  logic       advance;
  logic [23:0] codon;

  always_comb begin
    res = '0;
    codon_position_next = codon_position;
    cb_write = 1'b0;
    codon = canonical(sym_q);
    if (closes_q) begin
      codon_position_next = 2'd0;
      if (mode == MODE_BACK_CANON) begin
        res.bytes = {CODON_TAG[7:0], CODON_TAG[15:8], CODON_TAG[23:16]};
        res.count = 2'd3;
      end
    end else begin
      case (mode)
        MODE_BACK_CANON: begin
          res.bytes = {codon[7:0], codon[15:8], codon[23:16]};
          res.count = 2'd3;
        end
        MODE_TO_PROTEIN, MODE_TO_CANON: begin
          if (codon_position < 2'd2) begin
            cb_write = 1'b1;
            codon_position_next = codon_position + 2'd1;
          end else begin
            codon_position_next = 2'd0;
            res.bytes[0] = translate(codon_bytes[0], codon_bytes[1], sym_q);
            res.count = 2'd1;
            if (mode == MODE_TO_CANON) begin
              codon = canonical(res.bytes[0]);
              res.bytes = {codon[7:0], codon[15:8], codon[23:16]};
              res.count = 2'd3;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign advance   = ivalid && (res.count == 2'd0 || res_free);
  assign res_valid = ivalid && (res.count != 2'd0);
  assign in_ready  = !ivalid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
      codon_position <= 2'd0;
    end else begin
      if (in_ready) begin
        ivalid <= in_valid;
      end
      if (advance) begin
        codon_position <= codon_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sym_q    <= symbol;
      closes_q <= closes;
    end
    if (advance && cb_write) begin
      codon_bytes[codon_position[0]] <= sym_q;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ctr_serial.sv */
`default_nettype none

module ctr_serial
  import ctr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_valid,
  input  wire ctr_result_t res,
  output logic             res_free,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run
);

  logic            rvalid;
  logic [2:0][7:0] bytes;
  logic [1:0]      count;
  logic [1:0]      idx;

  assign out_valid   = rvalid;
  assign out_byte    = bytes[idx];
  assign last_of_run = (idx == count - 2'd1);
  assign res_free    = !rvalid || (out_ready && last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
      idx    <= 2'd0;
    end else if (res_free) begin
      rvalid <= res_valid;
      idx    <= 2'd0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      bytes <= res.bytes;
      count <= res.count;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/codon_translator.sv */
`default_nettype none

// channel | signals                          | word
// --------+----------------------------------+--------------------------------
// in      | in_valid in_ready symbol closes  | one sequence byte or a close
// out     | out_valid out_ready out_byte     | one converted byte, last_of_run
//         |   last_of_run                    |   marks the item's final word
// cfg     | cfg_valid cfg_ready mode         | mode register, always ready
//
// An item waits in the input register, where the translation runs, and its
// words leave from the result register one per cycle while out_ready is high.
// With out_ready high, the rate is one item per cycle for items with no or one
// word; codon output is set by the one-word result port. Reset clears valids,
// the codon position and sets mode 0. A stalled output holds its word; the input
// register takes a new word while the result register drains its last word.

module codon_translator
  import ctr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] symbol,
  input  wire logic       closes,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] mode
);

  mode_t       mode_q;
  logic        res_valid;
  logic        res_free;
  ctr_result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q <= MODE_TO_PROTEIN;
    end else if (cfg_valid && cfg_ready) begin
      mode_q <= mode_t'(mode);
    end
  end

  ctr_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode_q),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .symbol    (symbol),
    .closes    (closes),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free)
  );

  ctr_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res         (res),
    .res_free    (res_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

/* tb/tb_codon_translator.sv */
module tb_codon_translator;
  import ctr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 2000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] symbol;
  logic       closes;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] mode;

  codon_translator DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .symbol     (symbol),
    .closes     (closes),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_of_run(last_of_run),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .mode       (mode)
  );

  // translation state
  mode_t      cur_mode;
  logic [7:0] held [2];
  logic [1:0] held_cnt;
  out_word_t  pending_words[$];

  string amino_tbl = {"KNKNTTTTRSRSIIMI", "QHQHPPPPRRRRLLLL",
                      "EDEDAAAAGGGGVVVV", "*Y*YSSSS*CWCLFLF"};
  string nts = "ACGT";
  string protein_letters = "ARNDCQEGHIMLKFPSTWYV*";

  int n_err;
  int n_items;
  int n_words;
  int burst_left;
  bit gaps_on;
  int rx_style;
  int hold_seq;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int nt_index(input logic [7:0] b);
    case (b)
      "A": return 0;
      "C": return 1;
      "G": return 2;
      "T": return 3;
      default: return -1;
    endcase
  endfunction

  function automatic logic [7:0] amino_of(input logic [7:0] b1, input logic [7:0] b2,
                                          input logic [7:0] b3);
    int x;
    int y;
    int z;
    x = nt_index(b1);
    y = nt_index(b2);
    z = nt_index(b3);
    if (x < 0 || y < 0 || z < 0) return "M";
    return amino_tbl[x * 16 + y * 4 + z];
  endfunction

  function automatic logic [23:0] canon_codon_of(input logic [7:0] letter);
    case (letter)
      "A": return "GCT";
      "R": return "CGT";
      "N": return "AAT";
      "D": return "GAT";
      "C": return "TGT";
      "Q": return "CAA";
      "E": return "GAA";
      "G": return "GGT";
      "H": return "CAT";
      "I": return "ATT";
      "M": return "ATG";
      "L": return "TTA";
      "K": return "AAA";
      "F": return "TTT";
      "P": return "CCT";
      "S": return "TCT";
      "T": return "ACT";
      "W": return "TGG";
      "Y": return "TAT";
      "V": return "GTT";
      "*": return "TAG";
      default: return "ATG";
    endcase
  endfunction

  task automatic expect_word(input logic [7:0] ch, input logic last);
    out_word_t w;
    w.ch = ch;
    w.last = last;
    pending_words = {pending_words, w};
  endtask

  task automatic queue_codon(input logic [23:0] c);
    expect_word(c[23:16], 1'b0);
    expect_word(c[15:8], 1'b0);
    expect_word(c[7:0], 1'b1);
  endtask

  task automatic convert_item(input logic [7:0] s, input logic c);
    logic [7:0] aa;
    if (c) begin
      held_cnt = 2'd0;
      if (cur_mode == MODE_BACK_CANON) queue_codon("TAG");
    end else if (cur_mode == MODE_BACK_CANON) begin
      queue_codon(canon_codon_of(s));
    end else if (cur_mode != MODE_NONE) begin
      if (held_cnt < 2'd2) begin
        held[held_cnt[0]] = s;
        held_cnt = held_cnt + 2'd1;
      end else begin
        held_cnt = 2'd0;
        aa = amino_of(held[0], held[1], s);
        if (cur_mode == MODE_TO_PROTEIN) expect_word(aa, 1'b1);
        else queue_codon(canon_codon_of(aa));
      end
    end
  endtask

  task automatic flag(input string msg);
    n_err++;
    if (n_err <= 10) $display("ERROR: %s", msg);
  endtask

  // checks result words, then tracks config and input words
  always @(posedge clk) begin
    out_word_t w;
    if (rst) begin
      cur_mode = MODE_TO_PROTEIN;
      held_cnt = 2'd0;
    end else begin
      if (out_valid && out_ready) begin
        n_words++;
        if (pending_words.size() == 0) begin
          flag($sformatf("unexpected word %h last=%b", out_byte, last_of_run));
        end else begin
          w = pending_words.pop_front();
          if (out_byte !== w.ch || last_of_run !== w.last)
            flag($sformatf("word %0d: expected %h last=%b, got %h last=%b",
                           n_words, w.ch, w.last, out_byte, last_of_run));
        end
      end
      if (cfg_valid && cfg_ready) cur_mode = mode_t'(mode);
      if (in_valid && in_ready) begin
        n_items++;
        convert_item(symbol, closes);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no handshake for %0d cycles", IdleLimit);
    $display("tb_codon_translator NOT OK");
    $finish;
  end

  initial begin : receiver
    int hold;
    int seen;
    int tick;
    hold = 0;
    seen = 0;
    tick = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (seen != hold_seq) begin
        seen = hold_seq;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (rx_style)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= (tick % 5 >= 2);
        endcase
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input logic [7:0] s, input logic c);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    symbol <= s;
    closes <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_close();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    wait_drained();
    cfg_valid <= 1'b1;
    mode <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(input mode_t m);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_close();
    end else if (r < 88) begin
      if (m == MODE_BACK_CANON) send_item(protein_letters[$urandom_range(0, 20)], 1'b0);
      else send_item(nts[$urandom_range(0, 3)], 1'b0);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic test_to_protein();
    set_mode(MODE_TO_PROTEIN);
    send_text("ATG");
    send_item(8'h00, 1'b0);
    send_item("C", 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("AC");
    send_close();
  endtask

  task automatic test_to_canon();
    set_mode(MODE_TO_CANON);
    send_text("TGA");
    send_text("AnG");
  endtask

  task automatic test_back_canon();
    set_mode(MODE_BACK_CANON);
    send_text("A*Z");
    send_close();
  endtask

  // gathered bytes survive a mode change and mode 2 traffic
  task automatic test_mode_switch();
    set_mode(MODE_TO_PROTEIN);
    send_text("GC");
    set_mode(MODE_BACK_CANON);
    send_text("W");
    set_mode(MODE_TO_CANON);
    send_text("T");
  endtask

  // mode 3 ignores symbols but a close still drops the partial codon
  task automatic test_mode_none();
    set_mode(MODE_TO_PROTEIN);
    send_text("A");
    set_mode(MODE_NONE);
    send_text("X");
    send_close();
    set_mode(MODE_TO_PROTEIN);
    send_text("TGG");
  endtask

  task automatic test_output_stall();
    set_mode(MODE_TO_CANON);
    gaps_on = 1'b0;
    hold_seq++;
    for (int i = 0; i < 45; i++) send_item(nts[$urandom_range(0, 3)], 1'b0);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    mode_t plan[10];
    plan = '{MODE_TO_PROTEIN, MODE_TO_CANON, MODE_BACK_CANON, MODE_TO_PROTEIN, MODE_NONE,
             MODE_TO_CANON, MODE_BACK_CANON, MODE_TO_CANON, MODE_TO_PROTEIN,
             MODE_BACK_CANON};
    for (int p = 0; p < 10; p++) begin
      set_mode(plan[p]);
      gaps_on = (p != 3);
      rx_style = (p == 3) ? 0 : $urandom_range(0, 2);
      for (int i = 0; i < ((plan[p] == MODE_NONE) ? 12 : 28); i++) random_item(plan[p]);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    symbol = 8'h00;
    closes = 1'b0;
    cfg_valid = 1'b0;
    mode = MODE_TO_PROTEIN;
    n_err = 0;
    n_items = 0;
    n_words = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    rx_style = 1;
    hold_seq = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_to_protein();
    test_to_canon();
    test_back_canon();
    test_mode_switch();
    test_mode_none();
    test_output_stall();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (pending_words.size() != 0) flag($sformatf("%0d words never came", pending_words.size()));

    $display("run: %0d input words, %0d result words checked, %0d errors", n_items, n_words,
             n_err);
    $display("run: all four modes, mid-codon mode changes, closes, long output stall");
    if (n_err == 0) begin
      $display("tb_codon_translator OK");
    end else begin
      $display("tb_codon_translator NOT OK");
    end
    $finish;
  end

endmodule
